// ===== src/urav_pkg.sv =====
// Shared types and constants for the ultrasonic range averager.
// Used by the front end, the queue, the divider and the back end; no dependencies.
`timescale 1ns / 1ps

package urav_pkg;

   localparam int TICK_W  = 24;
   localparam int WIDTH_W = 16;
   localparam int COUNT_W = 8;
   localparam int SUM_W   = 19;
   localparam int DIST_W  = 11;
   localparam int DSR_W   = 8;
   localparam int STEP_W  = $clog2(SUM_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS     = 2'd2;

   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST  = 8'd1;
   localparam logic [WIDTH_W-1:0] TIMEOUT_TICKS_RST = 16'd30000;
   localparam logic [TICK_W-1:0]  GAP_TICKS_RST     = 24'd50000;

   localparam logic [TICK_W-1:0]  TRIG_LOW_TICKS  = 24'd2;
   localparam logic [TICK_W-1:0]  TRIG_HIGH_TICKS = 24'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
   localparam logic [SUM_W-1:0]   SUM_MAX         = 19'h7FFFF;
   localparam logic [DIST_W-1:0]  DIST_MAX        = 11'h7FF;

   // One tick's worth of work handed from the front end to the back end.
   typedef struct packed {
      logic               trig;
      logic               busy;
      logic               clr;
      logic               fin;
      logic               meas_valid;
      logic [WIDTH_W-1:0] width;
   } entry_type;

endpackage

// ===== src/urav_front.sv =====
// Front end: configuration registers and the per-tick measurement sequencer.
// Depends on urav_pkg; emits one queue entry for every accepted beat.
`timescale 1ns / 1ps

module urav_front #(
   parameter int MAX_SAMPLES = 255
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           start_req,
   input  logic                           echo,
   input  logic                           csr_we,
   input  logic [urav_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [urav_pkg::CSR_DATA_W-1:0] csr_wdata,
   output urav_pkg::entry_type            entry
);

   typedef enum logic [5:0] {
      F_IDLE  = 6'b000001,
      F_TLOW  = 6'b000010,
      F_THIGH = 6'b000100,
      F_WAIT  = 6'b001000,
      F_MEAS  = 6'b010000,
      F_GAP   = 6'b100000
   } front_state_type;

   front_state_type                   phase_ff, phase_in;
   logic [urav_pkg::TICK_W-1:0]       tick_ff, tick_in, tick_inc;
   logic [urav_pkg::WIDTH_W-1:0]      width_ff, width_in, fin_width;
   logic [urav_pkg::COUNT_W-1:0]      done_cnt_ff, done_cnt_in, done_new, eff_count;
   logic [urav_pkg::COUNT_W-1:0]      sample_count_ff;
   logic [urav_pkg::WIDTH_W-1:0]      timeout_ff;
   logic [urav_pkg::TICK_W-1:0]       gap_ff;
   logic                              finish;

   assign eff_count = (32'(sample_count_ff) > MAX_SAMPLES) ?
                      urav_pkg::COUNT_W'(MAX_SAMPLES) : sample_count_ff;
   assign tick_inc  = tick_ff + urav_pkg::TICK_W'(1);
   assign done_new  = (done_cnt_ff == urav_pkg::COUNT_MAX) ? done_cnt_ff :
                      done_cnt_ff + urav_pkg::COUNT_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      width_in    = width_ff;
      done_cnt_in = done_cnt_ff;
      finish      = 1'b0;
      fin_width   = width_ff;
      entry       = '0;
      entry.busy  = 1'b1;
      case (phase_ff)
         F_IDLE: begin
            entry.busy = 1'b0;
            if (start_req) begin
               done_cnt_in = '0;
               tick_in     = '0;
               width_in    = '0;
               entry.clr   = 1'b1;
               if (eff_count == '0) begin
                  entry.fin = 1'b1;
               end else begin
                  phase_in   = F_TLOW;
                  entry.busy = 1'b1;
               end
            end
         end
         F_TLOW: begin
            if (tick_inc >= urav_pkg::TRIG_LOW_TICKS) begin
               phase_in = F_THIGH;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         F_THIGH: begin
            entry.trig = 1'b1;
            if (tick_inc >= urav_pkg::TRIG_HIGH_TICKS) begin
               phase_in = F_WAIT;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         F_WAIT: begin
            if (tick_ff >= urav_pkg::TICK_W'(timeout_ff)) begin
               finish    = 1'b1;
               fin_width = '0;
            end else if (echo) begin
               width_in = urav_pkg::WIDTH_W'(1);
               phase_in = F_MEAS;
            end else begin
               tick_in = tick_inc;
            end
         end
         F_MEAS: begin
            if (echo && (width_ff < timeout_ff)) begin
               width_in = width_ff + urav_pkg::WIDTH_W'(1);
            end else begin
               finish = 1'b1;
            end
         end
         F_GAP: begin
            if (tick_inc >= gap_ff) begin
               phase_in = F_TLOW;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         default: begin
            phase_in   = F_IDLE;
            entry.busy = 1'b0;
         end
      endcase
      if (finish) begin
         entry.meas_valid = (fin_width != '0) && (fin_width < timeout_ff);
         entry.width      = fin_width;
         done_cnt_in      = done_new;
         width_in         = '0;
         tick_in          = '0;
         if (done_new >= eff_count) begin
            phase_in   = F_IDLE;
            entry.fin  = 1'b1;
            entry.busy = 1'b0;
         end else begin
            phase_in = (gap_ff == '0) ? F_TLOW : F_GAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= F_IDLE;
         tick_ff     <= '0;
         width_ff    <= '0;
         done_cnt_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         width_ff    <= width_in;
         done_cnt_ff <= done_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= urav_pkg::SAMPLE_COUNT_RST;
         timeout_ff      <= urav_pkg::TIMEOUT_TICKS_RST;
         gap_ff          <= urav_pkg::GAP_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            urav_pkg::CSR_SAMPLE_COUNT:  sample_count_ff <= csr_wdata[urav_pkg::COUNT_W-1:0];
            urav_pkg::CSR_TIMEOUT_TICKS: timeout_ff      <= csr_wdata[urav_pkg::WIDTH_W-1:0];
            urav_pkg::CSR_GAP_TICKS:     gap_ff          <= csr_wdata[urav_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== src/urav_fifo.sv =====
// Short queue of work entries between the front end and the back end.
// Depends on urav_pkg for the entry type and the queue depth.
`timescale 1ns / 1ps

module urav_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  urav_pkg::entry_type push_data,
   input  logic                pop,
   output urav_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   urav_pkg::entry_type             q_ff [urav_pkg::QUEUE_DEPTH];
   logic [urav_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [urav_pkg::QPTR_W:0]       count_ff, count_in;

   assign full  = (count_ff == (urav_pkg::QPTR_W+1)'(urav_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (urav_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (urav_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + urav_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + urav_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/urav_div.sv =====
// Serial restoring divider, one quotient bit per clock.
// Depends on urav_pkg for the operand widths; used only by the back end.
`timescale 1ns / 1ps

module urav_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [urav_pkg::SUM_W-1:0] dividend,
   input  logic [urav_pkg::DSR_W-1:0] divisor,
   output logic                       done,
   output logic [urav_pkg::SUM_W-1:0] quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [urav_pkg::STEP_W-1:0]   step_ff;
   logic [urav_pkg::DSR_W-1:0]    rem_ff, rem_in;
   logic [urav_pkg::DSR_W-1:0]    dsr_ff;
   logic [urav_pkg::SUM_W-1:0]    dvd_ff, dvd_in;
   logic [urav_pkg::DSR_W:0]      trial;
   logic                          ge;

   assign trial    = {rem_ff, dvd_ff[urav_pkg::SUM_W-1]};
   assign ge       = (trial >= {1'b0, dsr_ff});
   assign rem_in   = ge ? urav_pkg::DSR_W'(trial - {1'b0, dsr_ff}) :
                          trial[urav_pkg::DSR_W-1:0];
   assign dvd_in   = {dvd_ff[urav_pkg::SUM_W-2:0], ge};
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == urav_pkg::STEP_W'(urav_pkg::SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + urav_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== src/urav_back.sv =====
// Back end: distance conversion, burst accumulation, averaging and the result register.
// Depends on urav_pkg and instantiates urav_div.
`timescale 1ns / 1ps

module urav_back #(
   parameter int DIVISOR_CM = 58
) (
   input  logic                        clock,
   input  logic                        reset,
   input  urav_pkg::entry_type         head,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_trigger,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic                        rsp_no_valid,
   output logic [urav_pkg::DIST_W-1:0] rsp_mean_range
);

   localparam int RECIP_SHIFT = urav_pkg::WIDTH_W + urav_pkg::DSR_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = urav_pkg::WIDTH_W + RECIP_W;
   // The rounded-up reciprocal gives the exact truncated quotient for every 16-bit width.
   localparam logic [RECIP_W-1:0] CM_RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + DIVISOR_CM - 1) / DIVISOR_CM);

   typedef enum logic [4:0] {
      B_FETCH = 5'b00001,
      B_DIVW  = 5'b00010,
      B_END   = 5'b00100,
      B_DIVA  = 5'b01000,
      B_OUT   = 5'b10000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   urav_pkg::entry_type            ent_ff, ent_in;
   logic [urav_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [urav_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [urav_pkg::DIST_W-1:0]    avg_ff, avg_in;
   logic [urav_pkg::SUM_W:0]       sum_add;
   logic [PROD_W-1:0]              cm_prod;
   logic [urav_pkg::WIDTH_W-1:0]   cm;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_trigger_ff, rsp_busy_ff, rsp_done_ff, rsp_no_valid_ff;
   logic [urav_pkg::DIST_W-1:0]    rsp_mean_range_ff;
   logic                           load;

   logic                           div_start, div_done;
   logic [urav_pkg::SUM_W-1:0]     div_dividend, div_quotient;
   logic [urav_pkg::DSR_W-1:0]     div_divisor;

   urav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign cm_prod = PROD_W'(ent_ff.width) * PROD_W'(CM_RECIP);
   assign cm      = cm_prod[RECIP_SHIFT +: urav_pkg::WIDTH_W];
   assign sum_add = (urav_pkg::SUM_W+1)'(sum_ff) + (urav_pkg::SUM_W+1)'(cm);
   assign load    = (state_ff == B_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = cnt_ff;
      case (state_ff)
         B_FETCH: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               ent_in = head;
               avg_in = '0;
               if (head.clr) begin
                  sum_in = '0;
                  cnt_in = '0;
               end
               if (head.meas_valid) begin
                  state_in = B_DIVW;
               end else if (head.fin) begin
                  state_in = B_END;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_DIVW: begin
            if (cm != '0) begin
               sum_in = sum_add[urav_pkg::SUM_W] ? urav_pkg::SUM_MAX :
                        sum_add[urav_pkg::SUM_W-1:0];
               if (cnt_ff != urav_pkg::COUNT_MAX) begin
                  cnt_in = cnt_ff + urav_pkg::COUNT_W'(1);
               end
            end
            state_in = ent_ff.fin ? B_END : B_OUT;
         end
         B_END: begin
            if (cnt_ff != '0) begin
               div_start = 1'b1;
               state_in  = B_DIVA;
            end else begin
               state_in = B_OUT;
            end
         end
         B_DIVA: begin
            if (div_done) begin
               avg_in   = (div_quotient[urav_pkg::SUM_W-1:urav_pkg::DIST_W] != '0) ?
                          urav_pkg::DIST_MAX : div_quotient[urav_pkg::DIST_W-1:0];
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load) begin
               state_in = B_FETCH;
            end
         end
         default: begin
            state_in = B_FETCH;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_FETCH;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      avg_ff <= avg_in;
      if (load) begin
         rsp_trigger_ff    <= ent_ff.trig;
         rsp_busy_ff       <= ent_ff.busy;
         rsp_done_ff       <= ent_ff.fin;
         rsp_no_valid_ff   <= ent_ff.fin && (cnt_ff == '0);
         rsp_mean_range_ff <= avg_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_trigger    = rsp_trigger_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_no_valid   = rsp_no_valid_ff;
   assign rsp_mean_range = rsp_mean_range_ff;

`ifndef SYNTHESIS
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff && !rsp_trigger_ff)
      else $error("Result beat marks done while busy or triggering.");

   a_no_valid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_no_valid_ff |-> rsp_done_ff && (rsp_mean_range_ff == '0))
      else $error("No-valid result without done or with a non-zero distance.");

   a_div_expected : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == B_DIVA))
      else $error("Divider finished while the back end was not waiting for it.");
`endif

endmodule

// ===== src/ultrasonic_range_averager_unit.sv =====
// Every request beat is one microsecond tick and gives exactly one response beat, in order.
// A tick passes the front end combinationally and is queued in a four-entry queue. The back
// end fetches a plain tick from the queue and then offers its response beat from its output
// state. The tick that closes a valid echo also passes a conversion state, where the width is
// turned into centimetres by a constant reciprocal multiplication, and the tick that closes a
// burst with valid data also waits while the 19-step serial divider forms the average. The
// queue lets the front end keep taking ticks while the divider runs, until the queue is full.
// There is no clearing pass after reset. Top level: instantiates urav_front, urav_fifo and
// urav_back.
`timescale 1ns / 1ps

module ultrasonic_range_averager_unit #(
   parameter int MAX_SAMPLES = 255,
   parameter int DIVISOR_CM  = 58
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_start_req,
   input  logic                            req_echo,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_trigger,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic                            rsp_no_valid,
   output logic [urav_pkg::DIST_W-1:0]     rsp_mean_range,
   input  logic                            csr_we,
   input  logic [urav_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [urav_pkg::CSR_DATA_W-1:0] csr_wdata
);

   urav_pkg::entry_type front_entry, q_head;
   logic                q_full, q_empty, q_pop, accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   urav_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .start_req (req_start_req),
      .echo      (req_echo),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .entry     (front_entry)
   );

   urav_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   urav_back #(
      .DIVISOR_CM (DIVISOR_CM)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_trigger    (rsp_trigger),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_no_valid   (rsp_no_valid),
      .rsp_mean_range (rsp_mean_range)
   );

endmodule

// ===== bench/ultrasonic_range_averager_unit_tb.sv =====
// Self-checking bench for ultrasonic_range_averager_unit: one response beat per tick, predicted
// in the bench and compared field by field. Depends on urav_pkg and the unit itself.
`timescale 1ns / 1ps

module ultrasonic_range_averager_unit_tb;

   localparam int HALF_PERIOD   = 10;
   localparam int MAX_SAMPLES   = 255;
   localparam int DIVISOR_CM    = 58;
   localparam int RANDOM_TICKS  = 150;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [urav_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_TRIG_LOW  = 6'b000010,
      ST_TRIG_HIGH = 6'b000100,
      ST_ECHO_WAIT = 6'b001000,
      ST_ECHO_HIGH = 6'b010000,
      ST_GAP       = 6'b100000
   } ranger_state_type;

   typedef struct packed {
      logic                        trig;
      logic                        busy;
      logic                        done;
      logic                        no_valid;
      logic [urav_pkg::DIST_W-1:0] mean_range;
   } range_beat_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_start_req;
   logic                            req_echo;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_trigger;
   logic                            rsp_busy_res;
   logic                            rsp_done_res;
   logic                            rsp_no_valid;
   logic [urav_pkg::DIST_W-1:0]     rsp_mean_range;
   logic                            csr_we;
   logic [urav_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [urav_pkg::CSR_DATA_W-1:0] csr_wdata;

   ranger_state_type                ranger_state;
   logic [urav_pkg::TICK_W-1:0]     tick_cnt;
   logic [urav_pkg::WIDTH_W-1:0]    echo_width;
   logic [urav_pkg::COUNT_W-1:0]    samples_taken;
   logic [urav_pkg::COUNT_W-1:0]    samples_counted;
   logic [urav_pkg::SUM_W-1:0]      range_sum;
   logic [urav_pkg::COUNT_W-1:0]    cfg_samples;
   logic [urav_pkg::WIDTH_W-1:0]    cfg_timeout;
   logic [urav_pkg::TICK_W-1:0]     cfg_gap;

   range_beat_type pending_beats[$];
   range_beat_type want_beat;

   bit quiet;
   int stall_left = 0;
   int mismatch_count = 0;
   int ticks_sent;
   int burst_ticks;
   int configs_written;
   int bursts_done = 0;
   int cycle_count = 0;

   ultrasonic_range_averager_unit #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .DIVISOR_CM (DIVISOR_CM)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_echo      (req_echo),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_trigger   (rsp_trigger),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_no_valid  (rsp_no_valid),
      .rsp_mean_range(rsp_mean_range),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic logic [urav_pkg::COUNT_W-1:0] burst_length();
      return (int'(cfg_samples) > MAX_SAMPLES) ? urav_pkg::COUNT_W'(MAX_SAMPLES) : cfg_samples;
   endfunction

   function automatic bit close_measurement();
      logic [urav_pkg::SUM_W:0]     total;
      logic [urav_pkg::WIDTH_W-1:0] cm;
      if (echo_width != 0 && echo_width < cfg_timeout) begin
         cm = urav_pkg::WIDTH_W'(echo_width / DIVISOR_CM);
         if (cm != 0) begin
            total = (urav_pkg::SUM_W+1)'(range_sum) + (urav_pkg::SUM_W+1)'(cm);
            range_sum = (total > (urav_pkg::SUM_W+1)'(urav_pkg::SUM_MAX)) ? urav_pkg::SUM_MAX :
                        total[urav_pkg::SUM_W-1:0];
            if (samples_counted != urav_pkg::COUNT_MAX) samples_counted++;
         end
      end
      if (samples_taken != urav_pkg::COUNT_MAX) samples_taken++;
      echo_width = '0;
      tick_cnt = '0;
      if (samples_taken >= burst_length()) begin
         ranger_state = ST_IDLE;
         return 1'b1;
      end
      ranger_state = (cfg_gap == 0) ? ST_TRIG_LOW : ST_GAP;
      return 1'b0;
   endfunction

   function automatic range_beat_type next_beat(input logic start, input logic echo);
      range_beat_type             beat;
      bit                         ended;
      logic [urav_pkg::SUM_W-1:0] mean;
      beat = '0;
      ended = 1'b0;
      case (ranger_state)
         ST_IDLE: begin
            if (start) begin
               samples_taken = '0;
               samples_counted = '0;
               range_sum = '0;
               tick_cnt = '0;
               echo_width = '0;
               if (burst_length() == 0) begin
                  beat.done = 1'b1;
                  beat.no_valid = 1'b1;
               end else begin
                  ranger_state = ST_TRIG_LOW;
                  beat.busy = 1'b1;
               end
            end
            return beat;
         end
         ST_TRIG_LOW: begin
            tick_cnt++;
            if (tick_cnt >= urav_pkg::TRIG_LOW_TICKS) begin
               ranger_state = ST_TRIG_HIGH;
               tick_cnt = '0;
            end
            beat.busy = 1'b1;
            return beat;
         end
         ST_TRIG_HIGH: begin
            tick_cnt++;
            if (tick_cnt >= urav_pkg::TRIG_HIGH_TICKS) begin
               ranger_state = ST_ECHO_WAIT;
               tick_cnt = '0;
            end
            beat.trig = 1'b1;
            beat.busy = 1'b1;
            return beat;
         end
         ST_ECHO_WAIT: begin
            if (tick_cnt >= urav_pkg::TICK_W'(cfg_timeout)) begin
               echo_width = '0;
               ended = close_measurement();
            end else if (echo) begin
               echo_width = urav_pkg::WIDTH_W'(1);
               ranger_state = ST_ECHO_HIGH;
            end else begin
               tick_cnt++;
            end
         end
         ST_ECHO_HIGH: begin
            if (echo && echo_width < cfg_timeout) echo_width++;
            else ended = close_measurement();
         end
         ST_GAP: begin
            tick_cnt++;
            if (tick_cnt >= cfg_gap) begin
               ranger_state = ST_TRIG_LOW;
               tick_cnt = '0;
            end
         end
         default: begin
            ranger_state = ST_IDLE;
            return beat;
         end
      endcase
      if (ended) begin
         beat.done = 1'b1;
         if (samples_counted == 0) begin
            beat.no_valid = 1'b1;
         end else begin
            mean = range_sum / urav_pkg::SUM_W'(samples_counted);
            beat.mean_range = (mean > urav_pkg::SUM_W'(urav_pkg::DIST_MAX)) ?
                              urav_pkg::DIST_MAX : mean[urav_pkg::DIST_W-1:0];
         end
      end else begin
         beat.busy = 1'b1;
      end
      return beat;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(2, 1);
      if (r < 97) return $urandom_range(8, 3);
      return $urandom_range(40, 15);
   endfunction

   function automatic int pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(4);
      if (r < 92) return $urandom_range(40, 5);
      return int'(cfg_timeout) + $urandom_range(2);
   endfunction

   function automatic int pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 15) return $urandom_range(57);
      if (r < 25) return int'(cfg_timeout) + $urandom_range(2);
      return 58 + $urandom_range(100);
   endfunction

   function automatic void check_field(input string name,
                                       input logic [urav_pkg::DIST_W-1:0] want,
                                       input logic [urav_pkg::DIST_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // A tick beat is predicted only once the handshake has taken it.
   task automatic send_tick(input logic start, input logic echo);
      int pause;
      pause = pick_pause();
      @(negedge clock);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_echo <= echo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_beats.push_back(next_beat(start, echo));
      ticks_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [urav_pkg::CSR_IDX_W-1:0] idx,
                            input logic [urav_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         urav_pkg::CSR_SAMPLE_COUNT:  cfg_samples = data[urav_pkg::COUNT_W-1:0];
         urav_pkg::CSR_TIMEOUT_TICKS: cfg_timeout = data[urav_pkg::WIDTH_W-1:0];
         urav_pkg::CSR_GAP_TICKS:     cfg_gap = data[urav_pkg::TICK_W-1:0];
         default: ;
      endcase
      configs_written++;
   endtask

   // Bits above the sample-count and timeout widths carry random data that the unit must drop.
   task automatic set_config(input logic [urav_pkg::COUNT_W-1:0] samples,
                             input logic [urav_pkg::WIDTH_W-1:0] timeout,
                             input logic [urav_pkg::TICK_W-1:0] gap);
      settle();
      write_reg(urav_pkg::CSR_SAMPLE_COUNT, {16'($urandom), samples});
      write_reg(urav_pkg::CSR_TIMEOUT_TICKS, {8'($urandom), timeout});
      write_reg(urav_pkg::CSR_GAP_TICKS, gap);
   endtask

   // Plays the sensor for one burst; a negative delay or width is drawn afresh per measurement.
   task automatic run_burst(input int delay_set, input int width_set, input int start_pct);
      ranger_state_type seen;
      int               delay;
      int               width;
      int               waited;
      int               high;
      logic             echo;
      logic             start;
      seen = ST_IDLE;
      delay = 0;
      width = 0;
      waited = 0;
      high = 0;
      send_tick(1'b1, 1'($urandom_range(1)));
      burst_ticks++;
      while (ranger_state != ST_IDLE) begin
         if (ranger_state == ST_ECHO_WAIT && seen != ST_ECHO_WAIT) begin
            delay = (delay_set < 0) ? pick_delay() : delay_set;
            width = (width_set < 0) ? pick_width() : width_set;
            waited = 0;
            high = 0;
         end
         seen = ranger_state;
         start = ($urandom_range(99) < start_pct);
         case (ranger_state)
            ST_ECHO_WAIT: echo = (waited >= delay) && (high < width);
            ST_ECHO_HIGH: echo = (high < width);
            default:      echo = ($urandom_range(99) < 10);
         endcase
         if (ranger_state == ST_ECHO_WAIT && !echo) waited++;
         if (echo && (ranger_state == ST_ECHO_WAIT || ranger_state == ST_ECHO_HIGH)) high++;
         send_tick(start, echo);
         burst_ticks++;
         if ($urandom_range(199) == 0) settle();
      end
   endtask

   task automatic test_defaults();
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      run_burst(0, 58, 0);
   endtask

   task automatic test_zero_count();
      set_config(8'd0, 16'd100, 24'd0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
   endtask

   task automatic test_start_while_busy();
      set_config(8'd2, 16'd0, 24'd0);
      run_burst(0, 1, 100);
   endtask

   task automatic test_unknown_register();
      set_config(8'd1, 16'd200, 24'd5);
      write_reg(CSR_UNUSED, 24'($urandom));
      run_burst(2, 70, 0);
   endtask

   task automatic test_timeout_edges();
      set_config(8'd1, 16'd59, 24'd2);
      run_burst(0, 58, 0);
      run_burst(1, 59, 0);
      run_burst(59, 10, 0);
      set_config(8'd2, 16'd1, 24'd0);
      run_burst(0, 5, 0);
   endtask

   task automatic test_config_extremes();
      set_config(8'd1, 16'hFFFF, 24'hFFFFFF);
      run_burst(0, 60, 0);
      quiet = 1'b1;
      set_config(8'd12, 16'd0, 24'd0);
      run_burst(0, 0, 5);
      quiet = 1'b0;
   endtask

   task automatic test_random_bursts();
      logic [urav_pkg::COUNT_W-1:0] samples;
      logic [urav_pkg::WIDTH_W-1:0] timeout;
      logic [urav_pkg::TICK_W-1:0]  gap;
      int                           r;
      int                           first;
      first = burst_ticks;
      while (burst_ticks - first < RANDOM_TICKS) begin
         quiet = ($urandom_range(3) == 0);
         r = $urandom_range(99);
         samples = urav_pkg::COUNT_W'((r < 10) ? 0 : (r < 25) ? 1 : $urandom_range(5, 2));
         r = $urandom_range(99);
         timeout = urav_pkg::WIDTH_W'((r < 8) ? $urandom_range(3) :
                                      (r < 18) ? 58 + $urandom_range(1) :
                                                 $urandom_range(150, 60));
         gap = urav_pkg::TICK_W'(($urandom_range(99) < 30) ? 0 : $urandom_range(12, 1));
         set_config(samples, timeout, gap);
         repeat ($urandom_range(3, 1)) begin
            repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom_range(1)));
            run_burst(-1, -1, 8);
         end
      end
      quiet = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_pause();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $display("%0t ns: response beat with nothing outstanding", $time);
            mismatch_count++;
         end else begin
            want_beat = pending_beats.pop_front();
            check_field("trigger", urav_pkg::DIST_W'(want_beat.trig),
                        urav_pkg::DIST_W'(rsp_trigger));
            check_field("busy", urav_pkg::DIST_W'(want_beat.busy),
                        urav_pkg::DIST_W'(rsp_busy_res));
            check_field("done", urav_pkg::DIST_W'(want_beat.done),
                        urav_pkg::DIST_W'(rsp_done_res));
            check_field("no_valid", urav_pkg::DIST_W'(want_beat.no_valid),
                        urav_pkg::DIST_W'(rsp_no_valid));
            check_field("mean range", want_beat.mean_range, rsp_mean_range);
            if (rsp_done_res) bursts_done++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Cycle limit reached with %0d beats outstanding", pending_beats.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_req = 1'b0;
      req_echo = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 1'b0;
      ticks_sent = 0;
      burst_ticks = 0;
      configs_written = 0;
      ranger_state = ST_IDLE;
      tick_cnt = '0;
      echo_width = '0;
      samples_taken = '0;
      samples_counted = '0;
      range_sum = '0;
      cfg_samples = urav_pkg::SAMPLE_COUNT_RST;
      cfg_timeout = urav_pkg::TIMEOUT_TICKS_RST;
      cfg_gap = urav_pkg::GAP_TICKS_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_zero_count();
      test_start_while_busy();
      test_unknown_register();
      test_timeout_edges();
      test_config_extremes();
      test_random_bursts();
      settle();

      $display("Sent %0d tick beats across %0d register writes; %0d bursts completed.",
               ticks_sent, configs_written, bursts_done);
      $display("Covered zero counts, zero and full timeouts, gaps, busy starts and averages.");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
